[sv/edge_trigger_with_hysteresis_top_defines.svh]
// shared assertion macros for the edge trigger
`ifndef EDGE_TRIGGER_WITH_HYSTERESIS_TOP_DEFINES_SVH
`define EDGE_TRIGGER_WITH_HYSTERESIS_TOP_DEFINES_SVH

// concurrent check on the rising clock edge, skipped while in reset
`define ETRIG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("etrig assertion failed");

// same check, with its own message
`define ETRIG_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

`endif

[sv/etrig_pkg.sv]
package etrig_pkg;

  localparam int SampleBits   = 12;
  localparam int PositionBits = 32;
  localparam int FractionBits = 15;

  localparam int CfgIdxBits = 2;
  localparam int CntBits    = $clog2(FractionBits);

  localparam logic [CfgIdxBits-1:0] CFG_LEVEL   = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_HYST    = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_FALLING = 2'd2;

  localparam logic [SampleBits-1:0] LevelReset = SampleBits'(2048);

  typedef logic [SampleBits-1:0]   sample_t;
  typedef logic [PositionBits-1:0] position_t;
  typedef logic [FractionBits:0]   fraction_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROUND,
    ST_LOAD
  } etrig_state_e;

endpackage

[sv/etrig_sample_if.sv]
interface etrig_sample_if;
  import etrig_pkg::*;

  logic      valid;
  logic      ready;
  sample_t   sample;
  position_t sample_position;

  modport source (output valid, output sample, output sample_position, input ready);
  modport sink   (input valid, input sample, input sample_position, output ready);
endinterface

[sv/etrig_hit_if.sv]
interface etrig_hit_if;
  import etrig_pkg::*;

  logic      valid;
  logic      ready;
  position_t hit_position;
  fraction_t crossing_fraction;

  modport source (output valid, output hit_position, output crossing_fraction, input ready);
  modport sink   (input valid, input hit_position, input crossing_fraction, output ready);
endinterface

[sv/edge_trigger_with_hysteresis_top.sv]
// samples that do not fire: one request per cycle while idle, no result
// a firing sample: when the fraction is 0 or -1 the result goes straight to the load state,
//   otherwise through the division and rounding states of the one-bit-per-cycle shared divider
// next request taken once the result is loaded into the output register
// input is not ready while a fraction is being worked out or while it waits for the output
// reset (rst_ni low, asynchronous): disarmed, previous sample 0, level 2048, hysteresis 0,
//   rising edge, no result pending
module edge_trigger_with_hysteresis_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  etrig_sample_if.sink                        sample_i,
  etrig_hit_if.source                         hit_o,
  input  logic                                cfg_we_i,
  input  logic [etrig_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [etrig_pkg::SampleBits-1:0]    cfg_data_i
);
  import etrig_pkg::*;

  // configuration registers
  sample_t level_q;
  sample_t hyst_q;
  logic    falling_q;

  // trigger state
  logic    armed_q, armed_d;
  sample_t prev_q;

  // sequencer and divider
  etrig_state_e state_q, state_d;
  logic [CntBits-1:0]    cnt_q;
  logic [SampleBits-1:0] rem_q;
  logic [SampleBits-1:0] den_q;
  fraction_t             quo_q;
  position_t             pos_q;

  // output register
  logic      out_vld_q;
  position_t out_pos_q;
  fraction_t out_frac_q;

  logic accept;
  logic fire;
  logic frac_zero;
  logic frac_full;
  logic load_out;

  logic [SampleBits:0]   arm_lo_w;
  logic [SampleBits:0]   arm_hi_w;
  sample_t               arm_lo;
  sample_t               arm_hi;
  logic [SampleBits:0]   num;
  logic [SampleBits:0]   den;
  sample_t               num_mag;
  sample_t               den_mag;

  // shared subtract and compare unit
  logic [SampleBits:0]   unit_a;
  logic [SampleBits+1:0] unit_diff;
  logic                  unit_ge;

  assign accept = sample_i.valid && sample_i.ready;

  // arm thresholds, clamped to the sample range
  assign arm_lo_w = {1'b0, level_q} - {1'b0, hyst_q};
  assign arm_hi_w = {1'b0, level_q} + {1'b0, hyst_q};
  assign arm_lo   = arm_lo_w[SampleBits] ? '0 : arm_lo_w[SampleBits-1:0];
  assign arm_hi   = arm_hi_w[SampleBits] ? '1 : arm_hi_w[SampleBits-1:0];

  always_comb begin
    armed_d = armed_q;
    fire    = 1'b0;
    if (!armed_q) begin
      armed_d = falling_q ? (sample_i.sample >= arm_hi) : (sample_i.sample <= arm_lo);
    end else if (falling_q ? (sample_i.sample <= level_q) : (sample_i.sample >= level_q)) begin
      armed_d = 1'b0;
      fire    = 1'b1;
    end
  end

  // crossing ratio operands: level minus current over current minus previous
  assign num     = {1'b0, level_q} - {1'b0, sample_i.sample};
  assign den     = {1'b0, sample_i.sample} - {1'b0, prev_q};
  assign num_mag = num[SampleBits] ? SampleBits'(-num) : num[SampleBits-1:0];
  assign den_mag = den[SampleBits] ? SampleBits'(-den) : den[SampleBits-1:0];

  // zero when either side is zero or both point the same way
  assign frac_zero = (num == '0) || (den == '0) || (num[SampleBits] == den[SampleBits]);
  assign frac_full = num_mag >= den_mag;

  // long-division step doubles the remainder, rounding step adds half the divisor
  assign unit_a    = (state_q == ST_ROUND) ? ({1'b0, rem_q} + {2'b00, den_q[SampleBits-1:1]})
                                           : {rem_q, 1'b0};
  assign unit_diff = {1'b0, unit_a} - {2'b00, den_q};
  assign unit_ge   = !unit_diff[SampleBits+1];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && fire) begin
          state_d = (frac_zero || frac_full) ? ST_LOAD : ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // handshake outputs
  always_comb begin
    sample_i.ready = (state_q == ST_IDLE);
    load_out       = (state_q == ST_LOAD) && (!out_vld_q || hit_o.ready);
  end

  assign hit_o.valid             = out_vld_q;
  assign hit_o.hit_position      = out_pos_q;
  assign hit_o.crossing_fraction = out_frac_q;

  // configuration writes, index three and up are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= LevelReset;
      hyst_q    <= '0;
      falling_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEVEL:   level_q   <= cfg_data_i;
        CFG_HYST:    hyst_q    <= cfg_data_i;
        CFG_FALLING: falling_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      armed_q   <= 1'b0;
      prev_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        armed_q <= armed_d;
        prev_q  <= sample_i.sample;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (hit_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // divider datapath and result payload
  always_ff @(posedge clk_i) begin
    if (accept && fire) begin
      pos_q <= sample_i.sample_position;
      rem_q <= num_mag;
      den_q <= den_mag;
      cnt_q <= CntBits'(FractionBits - 1);
      if (frac_zero) begin
        quo_q <= '0;
      end else if (frac_full) begin
        quo_q <= fraction_t'(1) << FractionBits;
      end else begin
        quo_q <= '0;
      end
    end else if (state_q == ST_DIV) begin
      rem_q <= unit_ge ? unit_diff[SampleBits-1:0] : unit_a[SampleBits-1:0];
      quo_q <= {quo_q[FractionBits-1:0], unit_ge};
      cnt_q <= cnt_q - 1'b1;
    end else if (state_q == ST_ROUND) begin
      // round to nearest, ties away from zero
      quo_q <= quo_q + fraction_t'(unit_ge);
    end
    if (load_out) begin
      out_pos_q  <= pos_q;
      out_frac_q <= '0 - quo_q;
    end
  end

endmodule

[sv/etrig_checker.sv]
module etrig_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [etrig_pkg::PositionBits-1:0] out_pos_i,
  input logic [etrig_pkg::FractionBits:0]   out_frac_i
);
  import etrig_pkg::*;

  `include "edge_trigger_with_hysteresis_top_defines.svh"

  // a stalled result holds
  `ETRIG_ASSERT(a_out_hold, clk_i, rst_ni,
                out_valid_i && !out_ready_i |=>
                out_valid_i && $stable(out_pos_i) && $stable(out_frac_i))

  // fraction lies in minus one to zero
  `ETRIG_ASSERT_MSG(a_frac_sign, clk_i, rst_ni,
                    out_valid_i |-> (out_frac_i == '0) || out_frac_i[FractionBits],
                    "positive crossing fraction")

  // a new result comes only out of the busy period of a firing sample
  `ETRIG_ASSERT(a_res_from_busy, clk_i, rst_ni, $rose(out_valid_i) |-> $past(!in_ready_i))

endmodule

bind edge_trigger_with_hysteresis_top etrig_checker u_etrig_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (hit_o.valid),
  .out_ready_i (hit_o.ready),
  .out_pos_i   (hit_o.hit_position),
  .out_frac_i  (hit_o.crossing_fraction)
);
